### rtl/core/lom_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Limit order matching package
// Shared types and codes for the front queue and the matching engine.
// ----------------------------------------------------------------------------
package lom_pkg;

    localparam logic [1:0] ACT_SUBMIT = 2'd0;
    localparam logic [1:0] ACT_CANCEL = 2'd1;
    localparam logic [1:0] ACT_MODIFY = 2'd2;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    localparam int QTY_BITS = 32;

    typedef enum logic [1:0] {
        OT_LIMIT  = 2'd0,
        OT_MARKET = 2'd1,
        OT_IOC    = 2'd2,
        OT_FOK    = 2'd3
    } t_otype;

    typedef enum logic [1:0] {
        K_SUBMIT = 2'd0,
        K_CANCEL = 2'd1,
        K_MODIFY = 2'd2,
        K_IGNORE = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        OC_DONE      = 3'd0,
        OC_RESTED    = 3'd1,
        OC_DISCARDED = 3'd2,
        OC_NOT_FOUND = 3'd3,
        OC_ZERO_QTY  = 3'd4,
        OC_KILLED    = 3'd5,
        OC_FULL      = 3'd6
    } t_outcome;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND,
        ST_FIND_DONE,
        ST_FOK,
        ST_BEST,
        ST_FILL,
        ST_SETTLE,
        ST_FREE,
        ST_REST,
        ST_SUMMARY,
        ST_EMIT
    } t_state;

    // Classified item handed from the front queue to the engine
    typedef struct packed {
        t_kind                kind;
        logic [63:0]          ord_id;
        logic                 side;
        t_otype               otype;
        logic [QTY_BITS-1:0]  qty;
        logic [63:0]          ts;
    } t_cmd;

    // One buffered trade: maker id, execution price, fill quantity
    typedef struct packed {
        logic [63:0]          maker_id;
        logic [31:0]          price;
        logic [QTY_BITS-1:0]  qty;
    } t_trade;

    typedef struct packed {
        logic                 trade_valid;
        t_outcome             outcome;
        logic                 last_item;
        logic [63:0]          buy_id;
        logic [63:0]          sell_id;
        logic [31:0]          trade_price;
        logic [QTY_BITS-1:0]  trade_qty;
        logic [63:0]          trade_time;
        logic [31:0]          best_bid;
        logic [31:0]          best_ask;
        logic [6:0]           live_orders;
    } t_result;

endpackage
`default_nettype wire

### rtl/core/lom_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Limit order matching front
// Accepts items, classifies them, normalises the price and queues them.
// ----------------------------------------------------------------------------
module lom_front import lom_pkg::*; #(
    parameter int PRICE_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [1:0]            i_action,
    input  wire logic [63:0]           i_ord_id,
    input  wire logic                  i_side,
    input  wire logic [1:0]            i_order_type,
    input  wire logic [31:0]           i_price,
    input  wire logic [31:0]           i_quantity,
    input  wire logic [63:0]           i_timestamp,
    output logic                       o_q_valid,
    output t_cmd                       o_q_cmd,
    output logic [PRICE_BITS-1:0]      o_q_lim,
    input  wire logic                  i_q_pop
);

    t_cmd                  r_cmd [2];
    logic [PRICE_BITS-1:0] r_lim [2];
    logic                  r_wr_ptr, r_rd_ptr;
    logic [1:0]            r_count;

    t_cmd                  cls_cmd;
    logic [PRICE_BITS-1:0] cls_lim;
    logic [63:0]           price_w;
    logic                  accept;

    assign busy      = (r_count == 2'd2);
    assign accept    = start && !busy;
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_cmd   = r_cmd[r_rd_ptr];
    assign o_q_lim   = r_lim[r_rd_ptr];

    // Mask to the tick width, raise zero to one tick
    assign price_w = 64'(i_price);
    assign cls_lim = (price_w[PRICE_BITS-1:0] == '0) ? PRICE_BITS'(1)
                                                     : price_w[PRICE_BITS-1:0];

    always_comb begin
        cls_cmd.ord_id = i_ord_id;
        cls_cmd.side   = i_side;
        cls_cmd.otype  = t_otype'(i_order_type);
        cls_cmd.qty    = i_quantity;
        cls_cmd.ts     = i_timestamp;
        unique case (i_action)
            ACT_SUBMIT: cls_cmd.kind = K_SUBMIT;
            ACT_CANCEL: cls_cmd.kind = K_CANCEL;
            ACT_MODIFY: cls_cmd.kind = K_MODIFY;
            default:    cls_cmd.kind = K_IGNORE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (accept) begin
                r_cmd[r_wr_ptr] <= cls_cmd;
                r_lim[r_wr_ptr] <= cls_lim;
                r_wr_ptr        <= ~r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (accept && !i_q_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!accept && i_q_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/core/lom_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Limit order matching engine
// Carries out one queued item by sweeps over the slot table and emits results.
// ----------------------------------------------------------------------------
module lom_engine import lom_pkg::*; #(
    parameter int ORDER_SLOTS = 64,
    parameter int PRICE_BITS  = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_q_valid,
    input  wire t_cmd                  i_q_cmd,
    input  wire logic [PRICE_BITS-1:0] i_q_lim,
    output logic                       o_q_pop,
    output logic                       o_res_valid,
    output t_result                    o_res
);

    localparam int IW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
    localparam int CW = $clog2(ORDER_SLOTS + 1);
    localparam int SW = QTY_BITS + IW + 1;
    localparam logic [IW-1:0] SLOT_LAST = IW'(ORDER_SLOTS - 1);

    typedef struct packed {
        logic [63:0]           id;
        logic                  side;
        logic [PRICE_BITS-1:0] price;
        logic [QTY_BITS-1:0]   qty;
        logic [31:0]           arrival;
    } t_slot;

    function automatic logic [31:0] lo32(input logic [PRICE_BITS-1:0] p);
        logic [63:0] w;
        w = 64'(p);
        return w[31:0];
    endfunction

    // Slot table and trade buffer
    t_slot  mem_slot [ORDER_SLOTS];
    t_slot  r_rd_data;
    logic   mem_we;
    logic [IW-1:0] mem_waddr;
    t_slot  mem_wdata;

    t_trade mem_trade [ORDER_SLOTS];
    t_trade r_tb_rdata;
    logic   tb_we;
    logic [IW-1:0] tb_waddr;
    t_trade tb_wdata;

    t_state r_state, n_state;
    t_cmd   r_cmd, n_cmd;
    logic [PRICE_BITS-1:0] r_lim, n_lim;
    logic   r_side, n_side;
    t_otype r_type, n_type;
    logic [QTY_BITS-1:0] r_qty, n_qty;
    t_outcome r_outcome, n_outcome;

    logic [IW-1:0] r_scan_addr, n_scan_addr;
    logic   r_issue, n_issue;
    logic   r_proc_v, n_proc_v;
    logic [IW-1:0] r_proc_idx, n_proc_idx;

    logic   r_found, n_found;
    t_slot  r_hit, n_hit;
    logic [IW-1:0] r_hit_idx, n_hit_idx;
    logic [31:0] r_hit_age, n_hit_age;
    logic [SW-1:0] r_sum, n_sum;

    logic   r_valid [ORDER_SLOTS];
    logic   n_valid [ORDER_SLOTS];
    logic [31:0] r_arr_cnt, n_arr_cnt;
    logic [CW-1:0] r_trade_cnt, n_trade_cnt;
    logic [PRICE_BITS-1:0] r_bb, n_bb, r_ba, n_ba;
    logic [CW-1:0] r_live, n_live;

    logic    r_res_valid, n_res_valid;
    t_result r_res, n_res;

    // Entry under evaluation in the process stage
    t_slot  e;
    logic   ev, opp, e_opp, e_cross, e_better, any_price;
    logic [31:0] e_age;
    logic [QTY_BITS-1:0] fill;
    logic [CW-1:0] tc_minus;
    logic [IW-1:0] tc_last, scan_last;
    logic   scan_done, in_scan, start_scan, is_last;

    assign e         = r_rd_data;
    assign ev        = r_valid[r_proc_idx];
    assign opp       = ~r_side;
    assign any_price = (r_type == OT_MARKET);
    assign e_opp     = ev && (e.side == opp);
    assign e_cross   = opp ? (e.price <= r_lim) : (e.price >= r_lim);
    assign e_age     = r_arr_cnt - e.arrival;
    assign e_better  = !r_found ? 1'b1 :
                       (e.price == r_hit.price) ? (e_age > r_hit_age) :
                       (opp ? (e.price < r_hit.price) : (e.price > r_hit.price));
    assign fill      = (r_qty < r_hit.qty) ? r_qty : r_hit.qty;
    assign tc_minus  = r_trade_cnt - CW'(1);
    assign tc_last   = tc_minus[IW-1:0];
    assign scan_last = (r_state == ST_EMIT) ? tc_last : SLOT_LAST;
    assign scan_done = r_proc_v && (r_proc_idx == scan_last);
    assign is_last   = (r_proc_idx == tc_last);
    assign in_scan   = (r_state == ST_FIND) || (r_state == ST_FOK) ||
                       (r_state == ST_BEST) || (r_state == ST_FREE) ||
                       (r_state == ST_SUMMARY) || (r_state == ST_EMIT);

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_slot[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem_slot[r_scan_addr];
    end

    always_ff @(posedge i_clk) begin
        if (tb_we) begin
            mem_trade[tb_waddr] <= tb_wdata;
        end
        r_tb_rdata <= mem_trade[r_scan_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ORDER_SLOTS; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_arr_cnt   <= '0;
            r_trade_cnt <= '0;
            r_issue     <= 1'b0;
            r_proc_v    <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_arr_cnt   <= n_arr_cnt;
            r_trade_cnt <= n_trade_cnt;
            r_issue     <= n_issue;
            r_proc_v    <= n_proc_v;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_lim       <= n_lim;
        r_side      <= n_side;
        r_type      <= n_type;
        r_qty       <= n_qty;
        r_outcome   <= n_outcome;
        r_scan_addr <= n_scan_addr;
        r_proc_idx  <= n_proc_idx;
        r_found     <= n_found;
        r_hit       <= n_hit;
        r_hit_idx   <= n_hit_idx;
        r_hit_age   <= n_hit_age;
        r_sum       <= n_sum;
        r_bb        <= n_bb;
        r_ba        <= n_ba;
        r_live      <= n_live;
        r_res       <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_lim       = r_lim;
        n_side      = r_side;
        n_type      = r_type;
        n_qty       = r_qty;
        n_outcome   = r_outcome;
        n_scan_addr = r_scan_addr;
        n_issue     = r_issue;
        n_proc_v    = 1'b0;
        n_proc_idx  = r_proc_idx;
        n_found     = r_found;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_hit_age   = r_hit_age;
        n_sum       = r_sum;
        n_valid     = r_valid;
        n_arr_cnt   = r_arr_cnt;
        n_trade_cnt = r_trade_cnt;
        n_bb        = r_bb;
        n_ba        = r_ba;
        n_live      = r_live;
        n_res_valid = 1'b0;
        n_res       = r_res;
        mem_we      = 1'b0;
        mem_waddr   = r_hit_idx;
        mem_wdata   = r_hit;
        tb_we       = 1'b0;
        tb_waddr    = r_trade_cnt[IW-1:0];
        tb_wdata    = '0;
        o_q_pop     = 1'b0;
        start_scan  = 1'b0;

        // Advance the read/process pipeline of a sweep
        if (in_scan) begin
            n_proc_v   = r_issue;
            n_proc_idx = r_scan_addr;
            if (r_issue) begin
                if (r_scan_addr == scan_last) begin
                    n_issue = 1'b0;
                end else begin
                    n_scan_addr = r_scan_addr + IW'(1);
                end
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop     = 1'b1;
                    n_cmd       = i_q_cmd;
                    n_lim       = i_q_lim;
                    n_side      = i_q_cmd.side;
                    n_type      = i_q_cmd.otype;
                    n_qty       = i_q_cmd.qty;
                    n_trade_cnt = '0;
                    start_scan  = 1'b1;
                    unique case (i_q_cmd.kind)
                        K_SUBMIT: begin
                            if (i_q_cmd.qty == '0) begin
                                n_outcome = OC_ZERO_QTY;
                                n_state   = ST_SUMMARY;
                            end else if (i_q_cmd.otype == OT_FOK) begin
                                n_state = ST_FOK;
                            end else begin
                                n_state = ST_BEST;
                            end
                        end
                        K_CANCEL, K_MODIFY: n_state = ST_FIND;
                        default: begin
                            n_outcome = OC_DISCARDED;
                            n_state   = ST_SUMMARY;
                        end
                    endcase
                end
            end
            ST_FIND: begin
                if (r_proc_v && ev && (e.id == r_cmd.ord_id) && !r_found) begin
                    n_found   = 1'b1;
                    n_hit     = e;
                    n_hit_idx = r_proc_idx;
                end
                if (scan_done) begin
                    n_state = ST_FIND_DONE;
                end
            end
            ST_FIND_DONE: begin
                start_scan = 1'b1;
                n_state    = ST_SUMMARY;
                n_outcome  = OC_DONE;
                if (!r_found) begin
                    n_outcome = OC_NOT_FOUND;
                end else if (r_cmd.kind == K_CANCEL || r_cmd.qty == '0) begin
                    n_valid[r_hit_idx] = 1'b0;
                end else if (r_lim == r_hit.price && r_cmd.qty <= r_hit.qty) begin
                    // Shrink in place, keep priority
                    mem_we        = 1'b1;
                    mem_wdata.qty = r_cmd.qty;
                end else begin
                    // Pull and resubmit as a limit order on the resting side
                    n_valid[r_hit_idx] = 1'b0;
                    n_side             = r_hit.side;
                    n_type             = OT_LIMIT;
                    n_qty              = r_cmd.qty;
                    n_state            = ST_BEST;
                end
            end
            ST_FOK: begin
                if (r_proc_v && e_opp && e_cross) begin
                    n_sum = r_sum + SW'(e.qty);
                end
                if (scan_done) begin
                    start_scan = 1'b1;
                    if (n_sum < SW'(r_qty)) begin
                        n_outcome = OC_KILLED;
                        n_state   = ST_SUMMARY;
                    end else begin
                        n_state = ST_BEST;
                    end
                end
            end
            ST_BEST: begin
                if (r_proc_v && e_opp && (any_price || e_cross) && e_better) begin
                    n_found   = 1'b1;
                    n_hit     = e;
                    n_hit_idx = r_proc_idx;
                    n_hit_age = e_age;
                end
                if (scan_done) begin
                    n_state = n_found ? ST_FILL : ST_SETTLE;
                end
            end
            ST_FILL: begin
                tb_we             = 1'b1;
                tb_wdata.maker_id = r_hit.id;
                tb_wdata.price    = lo32(r_hit.price);
                tb_wdata.qty      = fill;
                n_trade_cnt       = r_trade_cnt + CW'(1);
                n_qty             = r_qty - fill;
                if (r_hit.qty == fill) begin
                    n_valid[r_hit_idx] = 1'b0;
                end else begin
                    mem_we        = 1'b1;
                    mem_wdata.qty = r_hit.qty - fill;
                end
                if (n_qty == '0) begin
                    n_state = ST_SETTLE;
                end else begin
                    start_scan = 1'b1;
                    n_state    = ST_BEST;
                end
            end
            ST_SETTLE: begin
                start_scan = 1'b1;
                if (r_qty == '0) begin
                    n_outcome = OC_DONE;
                    n_state   = ST_SUMMARY;
                end else if (r_type != OT_LIMIT) begin
                    n_outcome = OC_DISCARDED;
                    n_state   = ST_SUMMARY;
                end else begin
                    n_state = ST_FREE;
                end
            end
            ST_FREE: begin
                if (r_proc_v && !ev && !r_found) begin
                    n_found   = 1'b1;
                    n_hit_idx = r_proc_idx;
                end
                if (scan_done) begin
                    if (n_found) begin
                        n_state = ST_REST;
                    end else begin
                        start_scan = 1'b1;
                        n_outcome  = OC_FULL;
                        n_state    = ST_SUMMARY;
                    end
                end
            end
            ST_REST: begin
                mem_we             = 1'b1;
                mem_wdata.id       = r_cmd.ord_id;
                mem_wdata.side     = r_side;
                mem_wdata.price    = r_lim;
                mem_wdata.qty      = r_qty;
                mem_wdata.arrival  = r_arr_cnt;
                n_valid[r_hit_idx] = 1'b1;
                n_arr_cnt          = r_arr_cnt + 32'd1;
                n_outcome          = OC_RESTED;
                start_scan         = 1'b1;
                n_state            = ST_SUMMARY;
            end
            ST_SUMMARY: begin
                if (r_proc_v && ev) begin
                    n_live = r_live + CW'(1);
                    if (e.side == SIDE_BUY) begin
                        if (e.price > r_bb) begin
                            n_bb = e.price;
                        end
                    end else if (r_ba == '0 || e.price < r_ba) begin
                        n_ba = e.price;
                    end
                end
                if (scan_done) begin
                    if (r_trade_cnt == '0) begin
                        // No trade: a single empty result
                        n_res_valid       = 1'b1;
                        n_res             = '0;
                        n_res.outcome     = r_outcome;
                        n_res.last_item   = 1'b1;
                        n_res.best_bid    = lo32(n_bb);
                        n_res.best_ask    = lo32(n_ba);
                        n_res.live_orders = 7'(n_live);
                        n_state           = ST_IDLE;
                    end else begin
                        start_scan = 1'b1;
                        n_state    = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (r_proc_v) begin
                    n_res_valid       = 1'b1;
                    n_res.trade_valid = 1'b1;
                    n_res.last_item   = is_last;
                    n_res.outcome     = is_last ? r_outcome : OC_DONE;
                    n_res.buy_id      = (r_side == SIDE_BUY) ? r_cmd.ord_id
                                                             : r_tb_rdata.maker_id;
                    n_res.sell_id     = (r_side == SIDE_BUY) ? r_tb_rdata.maker_id
                                                             : r_cmd.ord_id;
                    n_res.trade_price = r_tb_rdata.price;
                    n_res.trade_qty   = r_tb_rdata.qty;
                    n_res.trade_time  = r_cmd.ts;
                    n_res.best_bid    = lo32(r_bb);
                    n_res.best_ask    = lo32(r_ba);
                    n_res.live_orders = 7'(r_live);
                end
                if (scan_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (start_scan) begin
            n_scan_addr = '0;
            n_issue     = 1'b1;
            n_proc_v    = 1'b0;
            n_found     = 1'b0;
            n_sum       = '0;
            if (n_state == ST_SUMMARY) begin
                n_bb   = '0;
                n_ba   = '0;
                n_live = '0;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/core/limit_order_matching_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Limit order matching top level
// Price-time priority order book over a table of resting orders.
//
//   channel   handshake                   payload
//   --------  --------------------------  --------------------------------------
//   item in   start & !busy               action, ord_id, side, order_type,
//                                         price, quantity, timestamp
//   result    o_result_valid (one cycle)  trade_valid, outcome, last_item, ids,
//                                         trade price/qty/time, best bid/ask,
//                                         live_orders
//
// Steps: a sweep of the slot table reads one entry a cycle through the single
//   read port. Per item: the pop; an id sweep and decision step for cancel and
//   modify; a fill-or-kill sweep; a best-price sweep and fill step per trade,
//   one more sweep if quantity is left, a settle step; a free-slot sweep and
//   rest step; a summary sweep. Trades then stream out one per cycle.
// Reset: synchronous, active low; empties the book and the item queue.
// Stalls: the receiver cannot stall; busy rises only while two items wait.
// ----------------------------------------------------------------------------
module limit_order_matching_top import lom_pkg::*; #(
    parameter int ORDER_SLOTS = 64,
    parameter int PRICE_BITS  = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_action,
    input  wire logic [63:0] i_ord_id,
    input  wire logic        i_side,
    input  wire logic [1:0]  i_order_type,
    input  wire logic [31:0] i_price,
    input  wire logic [31:0] i_quantity,
    input  wire logic [63:0] i_timestamp,
    output logic             o_result_valid,
    output logic             o_trade_valid,
    output logic [2:0]       o_outcome,
    output logic             o_last_item,
    output logic [63:0]      o_buy_id,
    output logic [63:0]      o_sell_id,
    output logic [31:0]      o_trade_price,
    output logic [31:0]      o_trade_qty,
    output logic [63:0]      o_trade_time,
    output logic [31:0]      o_best_bid,
    output logic [31:0]      o_best_ask,
    output logic [6:0]       o_live_orders
);

    logic                  q_valid;
    t_cmd                  q_cmd;
    logic [PRICE_BITS-1:0] q_lim;
    logic                  q_pop;
    t_result               res;

    // Front: take items in, classify and queue them
    lom_front #(
        .PRICE_BITS (PRICE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_ord_id     (i_ord_id),
        .i_side       (i_side),
        .i_order_type (i_order_type),
        .i_price      (i_price),
        .i_quantity   (i_quantity),
        .i_timestamp  (i_timestamp),
        .o_q_valid    (q_valid),
        .o_q_cmd      (q_cmd),
        .o_q_lim      (q_lim),
        .i_q_pop      (q_pop)
    );

    // Back: match against the book, rest, cancel, report
    lom_engine #(
        .ORDER_SLOTS (ORDER_SLOTS),
        .PRICE_BITS  (PRICE_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .i_q_lim     (q_lim),
        .o_q_pop     (q_pop),
        .o_res_valid (o_result_valid),
        .o_res       (res)
    );

    assign o_trade_valid = res.trade_valid;
    assign o_outcome     = res.outcome;
    assign o_last_item   = res.last_item;
    assign o_buy_id      = res.buy_id;
    assign o_sell_id     = res.sell_id;
    assign o_trade_price = res.trade_price;
    assign o_trade_qty   = res.trade_qty;
    assign o_trade_time  = res.trade_time;
    assign o_best_bid    = res.best_bid;
    assign o_best_ask    = res.best_ask;
    assign o_live_orders = res.live_orders;

    // An empty result is always the only one for its item
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_trade_valid |-> o_last_item)
        else $error("empty result not marked last");

    // Only the final result of an item carries a non-done outcome
    a_outcome_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_last_item |-> o_outcome == OC_DONE)
        else $error("outcome on a non-final result");

    // The book never holds more orders than it has slots
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> o_live_orders <= 7'(ORDER_SLOTS))
        else $error("live order count beyond table size");

    // No result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid)
        else $error("result strobe after reset");

endmodule
`default_nettype wire
